// File: rtl/srd_pkg.sv
// Shared types and constants of the sprite row run-length decoder.
// No dependencies; every other file in rtl imports this package.
package srd_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int ROW_IDX_W = $clog2(MAX_DIM);

    localparam int MODE_W    = 2;
    localparam int DIM_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int PIX_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_UNCOMP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PACKED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd2;

    localparam logic [MODE_W-1:0] RESET_MODE  = MODE_PAIR;
    localparam logic [DIM_W-1:0]  RESET_WIDTH = 12'd32;
    localparam logic [DIM_W-1:0]  RESET_COUNT = 12'd32;

    localparam logic [BYTE_W-1:0] RAW_TYPE        = 8'hFF;
    localparam logic [2:0]        PACKED_RAW_CODE = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] coding_mode;
        logic [DIM_W-1:0]  row_width;
        logic [DIM_W-1:0]  row_count;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic [LEN_W-1:0]  run_length;
        logic              end_of_row;
        logic              end_of_frame;
    } result_t;

endpackage

// File: rtl/sprite_rle_row_decoder.sv
// Sprite row run-length decoder: one segment byte per cycle in, runs of 1 to 256 pixels out.
// A byte that produces a run reaches the m_ ports via the input register, then the result register.
// Throughput: one byte per cycle while the result side takes runs; a held result stalls the input.
// Pair-mode headers, raw-type length bytes and packed raw headers produce no run.
// Reset (synchronous, aresetn low) clears parse phase, counters and both valid flags and
// loads coding_mode 1, row_width 32, row_count 32. Depends on srd_pkg, srd_cfg, srd_parser.
module sprite_rle_row_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [srd_pkg::BYTE_W-1:0]    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srd_pkg::BYTE_W-1:0]    m_pixel_value,
    output logic [srd_pkg::LEN_W-1:0]     m_run_length,
    output logic                          m_end_of_row,
    output logic                          m_end_of_frame,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srd_pkg::DIM_W-1:0]     cfg_data
);
    import srd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              step;
    logic              out_take;
    cfg_t              cfg;
    result_t           result;

    assign advance  = !m_valid || m_ready;
    assign step     = in_valid_reg && advance;
    assign s_ready  = !in_valid_reg || advance;
    assign out_take = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    srd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .out_take  (out_take),
        .out_valid (m_valid),
        .result    (result)
    );

    assign m_pixel_value  = result.pixel_value;
    assign m_run_length   = result.run_length;
    assign m_end_of_row   = result.end_of_row;
    assign m_end_of_frame = result.end_of_frame;

endmodule

// File: rtl/srd_cfg.sv
// Configuration registers of the sprite row run-length decoder.
// Depends on srd_pkg for the register indexes and the cfg_t struct.
module srd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srd_pkg::DIM_W-1:0]     cfg_data,
    output srd_pkg::cfg_t                 cfg
);
    import srd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CODING_MODE: cfg_next.coding_mode = cfg_data[MODE_W-1:0];
                REG_ROW_WIDTH:   cfg_next.row_width   = cfg_data;
                REG_ROW_COUNT:   cfg_next.row_count   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coding_mode <= RESET_MODE;
            cfg_reg.row_width   <= RESET_WIDTH;
            cfg_reg.row_count   <= RESET_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/srd_parser.sv
// Segment parser and row accounting, with the result register.
// Depends on srd_pkg for the configuration and result structs.
module srd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [srd_pkg::BYTE_W-1:0] data_byte,
    input  srd_pkg::cfg_t              cfg,
    input  logic                       out_take,
    output logic                       out_valid,
    output srd_pkg::result_t           result
);
    import srd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_RAW
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BYTE_W-1:0]      held_reg, held_next;
    logic [LEN_W-1:0]       raw_reg, raw_next;
    logic [PIX_W-1:0]       pix_reg, pix_next;
    logic [ROW_IDX_W-1:0]   row_reg, row_next;
    logic                   out_valid_reg;
    result_t                result_reg;

    logic                   emit;
    logic                   seg_done;
    logic [BYTE_W-1:0]      run_value;
    logic [LEN_W-1:0]       run_len;
    logic [LEN_W-1:0]       raw_dec;
    logic [PIX_W-1:0]       pix_sum;
    logic [ROW_IDX_W-1:0]   row_inc;
    logic                   eor;
    logic                   eof;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        raw_next   = raw_reg;
        pix_next   = pix_reg;
        row_next   = row_reg;
        emit       = 1'b0;
        seg_done   = 1'b0;
        run_value  = data_byte;
        run_len    = LEN_W'(1);
        raw_dec    = (raw_reg != '0) ? raw_reg - LEN_W'(1) : raw_reg;
        eor        = 1'b0;
        eof        = 1'b0;

        unique case (phase_reg)
            PH_RAW: begin
                raw_next = raw_dec;
                seg_done = (raw_dec == '0);
                emit     = 1'b1;
                if (raw_dec == '0) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_LENGTH: begin
                if (held_reg == RAW_TYPE) begin
                    raw_next   = LEN_W'(data_byte) + LEN_W'(1);
                    phase_next = PH_RAW;
                end else begin
                    emit       = 1'b1;
                    seg_done   = 1'b1;
                    run_value  = held_reg;
                    run_len    = LEN_W'(data_byte) + LEN_W'(1);
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER: begin
                unique case (cfg.coding_mode)
                    MODE_UNCOMP: begin
                        emit     = 1'b1;
                        seg_done = 1'b1;
                    end
                    MODE_PAIR: begin
                        held_next  = data_byte;
                        phase_next = PH_LENGTH;
                    end
                    MODE_PACKED: begin
                        run_len = LEN_W'(data_byte[4:0]) + LEN_W'(1);
                        if (data_byte[7:5] == PACKED_RAW_CODE) begin
                            raw_next   = run_len;
                            phase_next = PH_RAW;
                        end else begin
                            emit      = 1'b1;
                            seg_done  = 1'b1;
                            run_value = BYTE_W'(data_byte[7:5]);
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        pix_sum = pix_reg + PIX_W'(run_len);
        row_inc = row_reg + ROW_IDX_W'(1);
        if (emit) begin
            pix_next = pix_sum;
            if (seg_done && (pix_sum >= PIX_W'(cfg.row_width))) begin
                eor      = 1'b1;
                pix_next = '0;
                row_next = row_inc;
                if (32'(row_inc) >= 32'(cfg.row_count)) begin
                    eof      = 1'b1;
                    row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            held_reg      <= '0;
            raw_reg       <= '0;
            pix_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                raw_reg   <= raw_next;
                pix_reg   <= pix_next;
                row_reg   <= row_next;
            end
            if (step && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            result_reg.pixel_value  <= run_value;
            result_reg.run_length   <= run_len;
            result_reg.end_of_row   <= eor;
            result_reg.end_of_frame <= eof;
        end
    end

    a_eof_has_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!result_reg.end_of_frame || result_reg.end_of_row))
        else $error("End of frame reported without end of row.");

    a_raw_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RAW) |-> (raw_reg != '0))
        else $error("Raw phase entered with no raw bytes pending.");

    a_raw_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_RAW) |=> (out_valid_reg && result_reg.run_length == LEN_W'(1)))
        else $error("Raw byte did not produce a single-pixel run.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_take) |-> !step)
        else $error("Parser advanced while the result register was stalled.");

endmodule
